// ----- hw/rtl/new_york_dst_offset_top_assert.svh -----
// Assertion macros shared by the New York offset RTL.
// Depends on nothing; included by the top level.
`ifndef NEW_YORK_DST_OFFSET_TOP_ASSERT_SVH
`define NEW_YORK_DST_OFFSET_TOP_ASSERT_SVH

// Consequence checked in the same cycle as the antecedent.
`define NYDST_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequence checked in the cycle after the antecedent.
`define NYDST_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/nydst_pkg.sv -----
// Types, widths and calendar constants for the New York offset block.
// No dependencies.
package nydst_pkg;

    // Payload widths.
    localparam int TIME_W = 40;
    localparam int OFS_W  = 10;

    typedef logic [TIME_W-1:0]        t_time;
    typedef logic signed [OFS_W-1:0]  t_offset;

    localparam t_offset OFS_DST = t_offset'(-4 * 60);
    localparam t_offset OFS_STD = t_offset'(-5 * 60);

    // A day is 675 << 7 seconds: the shift is free, the odd part is divided in two digits.
    localparam int SECS_PER_DAY = 86400;
    localparam int SEC_SHIFT    = 7;
    localparam int DAY_ODD      = 675;
    localparam int DAY_LO_W     = 16;
    localparam int XH_W         = TIME_W - SEC_SHIFT - DAY_LO_W;
    localparam int LO_W         = TIME_W - XH_W;
    localparam int Q1_W         = 8;
    localparam int R1_W         = 10;
    localparam int Y_W          = R1_W + DAY_LO_W;

    // Calendar value widths.
    localparam int DAY_W = Q1_W + DAY_LO_W;
    localparam int SOD_W = 17;
    localparam int ERA_W = 7;
    localparam int WQ_W  = 22;
    localparam int DOE_W = 18;
    localparam int YOE_W = 9;
    localparam int DOY_W = 9;
    localparam int WD_W  = 3;

    // Calendar constants.
    localparam int EPOCH_SHIFT   = 719468;
    localparam int DAYS_PER_ERA  = 146097;
    localparam int EPOCH_WEEKDAY = 4;
    localparam int DAYS_PER_WEEK = 7;
    localparam int DAYS_PER_YEAR = 365;
    localparam int SUN2_OFS      = 7;
    localparam int NOV_OFS       = 245;
    localparam int SOD_START     = 2 * 3600 + 5 * 3600;
    localparam int SOD_END       = 2 * 3600 + 4 * 3600;

    // Reciprocals: floor(x / D) = (x * M) >> S, exact for every x of the given width.
    localparam int R675_S = 36;
    localparam int R675_W = R675_S - $clog2(DAY_ODD) + 1;
    localparam logic [R675_W-1:0] R675_M =
        R675_W'(((64'd1 << R675_S) + 64'(DAY_ODD) - 64'd1) / 64'(DAY_ODD));

    localparam int RERA_S = 42;
    localparam int RERA_W = RERA_S - $clog2(DAYS_PER_ERA) + 1;
    localparam logic [RERA_W-1:0] RERA_M =
        RERA_W'(((64'd1 << RERA_S) + 64'(DAYS_PER_ERA) - 64'd1) / 64'(DAYS_PER_ERA));

    localparam int RWK_S = 27;
    localparam int RWK_W = RWK_S - $clog2(DAYS_PER_WEEK) + 1;
    localparam logic [RWK_W-1:0] RWK_M =
        RWK_W'(((64'd1 << RWK_S) + 64'(DAYS_PER_WEEK) - 64'd1) / 64'(DAYS_PER_WEEK));

    localparam int R1460_S = 29;
    localparam int R1460_W = R1460_S - $clog2(1460) + 1;
    localparam logic [R1460_W-1:0] R1460_M =
        R1460_W'(((64'd1 << R1460_S) + 64'd1459) / 64'd1460);

    localparam int R36524_S = 34;
    localparam int R36524_W = R36524_S - $clog2(36524) + 1;
    localparam logic [R36524_W-1:0] R36524_M =
        R36524_W'(((64'd1 << R36524_S) + 64'd36523) / 64'd36524);

    localparam int R365_S = 27;
    localparam int R365_W = R365_S - $clog2(DAYS_PER_YEAR) + 1;
    localparam logic [R365_W-1:0] R365_M =
        R365_W'(((64'd1 << R365_S) + 64'(DAYS_PER_YEAR) - 64'd1) / 64'(DAYS_PER_YEAR));

    localparam int R100_S = 16;
    localparam int R100_W = R100_S - $clog2(100) + 1;
    localparam logic [R100_W-1:0] R100_M =
        R100_W'(((64'd1 << R100_S) + 64'd99) / 64'd100);

    localparam int RDW_S = 12;
    localparam int RDW_W = RDW_S - $clog2(DAYS_PER_WEEK) + 1;
    localparam logic [RDW_W-1:0] RDW_M =
        RDW_W'(((64'd1 << RDW_S) + 64'(DAYS_PER_WEEK) - 64'd1) / 64'(DAYS_PER_WEEK));

endpackage

// ----- hw/rtl/nydst_if.sv -----
// Valid/ready channels for the New York offset block: input items and result items.
// Depends on nydst_pkg.
interface nydst_in_if;
    logic                 valid;
    logic                 ready;
    nydst_pkg::t_time     utc_seconds;

    modport source (output valid, output utc_seconds, input ready);
    modport sink   (input valid, input utc_seconds, output ready);
endinterface

interface nydst_out_if;
    logic                 valid;
    logic                 ready;
    nydst_pkg::t_offset   offset_minutes;
    logic                 dst_active;

    modport source (output valid, output offset_minutes, output dst_active, input ready);
    modport sink   (input valid, input offset_minutes, input dst_active, output ready);
endinterface

// ----- hw/rtl/new_york_dst_offset_top.sv -----
// New York UTC offset: UTC seconds in, -240 or -300 minutes and a DST flag out.
// Fifteen register stages, 0 to 14; a result is presented from stage 14.
// One item per cycle unless all stages are full and the output stalls; each stage holds while
// the stage after it is full and stalled, so bubbles close up and items enter while any stage is empty.
// Reset (synchronous, active low) empties the pipeline; data registers are not reset.
// Depends on nydst_pkg, nydst_if and new_york_dst_offset_top_assert.svh.
`include "new_york_dst_offset_top_assert.svh"

module new_york_dst_offset_top #(
    parameter int TIME_BITS = 40
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    nydst_in_if.sink            i_item,
    nydst_out_if.source         o_result
);

    localparam int NS     = 15;
    localparam int TIME_W = nydst_pkg::TIME_W;
    localparam int KEEP   = (TIME_BITS < TIME_W) ? TIME_BITS : TIME_W;
    localparam logic [TIME_W-1:0] T_MASK = {TIME_W{1'b1}} >> (TIME_W - KEEP);

    localparam int XH_W  = nydst_pkg::XH_W;
    localparam int LO_W  = nydst_pkg::LO_W;
    localparam int Q1_W  = nydst_pkg::Q1_W;
    localparam int R1_W  = nydst_pkg::R1_W;
    localparam int Y_W   = nydst_pkg::Y_W;
    localparam int DLO_W = nydst_pkg::DAY_LO_W;
    localparam int SSH   = nydst_pkg::SEC_SHIFT;
    localparam int DAY_W = nydst_pkg::DAY_W;
    localparam int SOD_W = nydst_pkg::SOD_W;
    localparam int ERA_W = nydst_pkg::ERA_W;
    localparam int WQ_W  = nydst_pkg::WQ_W;
    localparam int DOE_W = nydst_pkg::DOE_W;
    localparam int YOE_W = nydst_pkg::YOE_W;
    localparam int DOY_W = nydst_pkg::DOY_W;
    localparam int WD_W  = nydst_pkg::WD_W;

    localparam int P1_W    = XH_W + nydst_pkg::R675_W;
    localparam int P3_W    = Y_W + nydst_pkg::R675_W;
    localparam int PERA_W  = DAY_W + nydst_pkg::RERA_W;
    localparam int PWK_W   = DAY_W + nydst_pkg::RWK_W;
    localparam int P1460_W = DOE_W + nydst_pkg::R1460_W;
    localparam int P36K_W  = DOE_W + nydst_pkg::R36524_W;
    localparam int P365_W  = DOE_W + nydst_pkg::R365_W;
    localparam int P100_W  = YOE_W + nydst_pkg::R100_W;
    localparam int PDW_W   = DOY_W + nydst_pkg::RDW_W;

    localparam int Q1460_W = 7;
    localparam int Q36K_W  = 3;
    localparam int Y100_W  = 3;
    localparam int DQ_W    = 6;
    localparam int WM_W    = WD_W + 1;

    localparam logic [SOD_W-1:0] SOD_START_V = SOD_W'(nydst_pkg::SOD_START);
    localparam logic [SOD_W-1:0] SOD_END_V   = SOD_W'(nydst_pkg::SOD_END);
    localparam logic [SOD_W-1:0] SOD_DAY_V   = SOD_W'(nydst_pkg::SECS_PER_DAY);
    localparam logic [WM_W-1:0]  WEEK_WM     = WM_W'(nydst_pkg::DAYS_PER_WEEK);
    localparam logic [WD_W-1:0]  WEEK_WD     = WD_W'(nydst_pkg::DAYS_PER_WEEK);

    // Stage valids and per-stage advance enables.
    logic [NS-1:0] r_v;
    logic [NS-1:0] n_v;
    logic [NS-1:0] w_en;
    logic          w_out_free;

    assign w_out_free = !r_v[NS-1] || o_result.ready;

    // A stage may load when any stage from it to the output is empty or the output drains.
    for (genvar g = 0; g < NS; g++) begin : g_en
        assign w_en[g] = w_out_free || !(&r_v[NS-1:g]);
    end

    always_comb begin
        for (int k = 0; k < NS; k++) begin
            if (k == 0) begin
                n_v[k] = w_en[k] ? i_item.valid : r_v[k];
            end else begin
                n_v[k] = w_en[k] ? r_v[k-1] : r_v[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= n_v;
        end
    end

    assign i_item.ready = w_en[0];

    // Stage 0: capture the time and keep only the low TIME_BITS bits.
    logic [TIME_W-1:0] r0_t;

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r0_t <= i_item.utc_seconds & T_MASK;
        end
    end

    // Stage 1: high digit of (t >> 7) divided by 675.
    logic [P1_W-1:0] w1_prod;
    logic [Q1_W-1:0] r1_q1;
    logic [XH_W-1:0] r1_xh;
    logic [LO_W-1:0] r1_lo;

    assign w1_prod = P1_W'(r0_t[TIME_W-1 -: XH_W]) * P1_W'(nydst_pkg::R675_M);

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r1_q1 <= w1_prod[nydst_pkg::R675_S +: Q1_W];
            r1_xh <= r0_t[TIME_W-1 -: XH_W];
            r1_lo <= r0_t[LO_W-1:0];
        end
    end

    // Stage 2: remainder of the high digit.
    logic [Q1_W-1:0] r2_q1;
    logic [R1_W-1:0] r2_r1;
    logic [LO_W-1:0] r2_lo;

    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            r2_q1 <= r1_q1;
            r2_r1 <= R1_W'(r1_xh - XH_W'(r1_q1) * XH_W'(nydst_pkg::DAY_ODD));
            r2_lo <= r1_lo;
        end
    end

    // Stage 3: low digit, carrying the high remainder, divided by 675.
    logic [Y_W-1:0]   w3_y;
    logic [P3_W-1:0]  w3_prod;
    logic [Q1_W-1:0]  r3_q1;
    logic [DLO_W-1:0] r3_q2;
    logic [Y_W-1:0]   r3_y;
    logic [SSH-1:0]   r3_t7;

    assign w3_y    = {r2_r1, r2_lo[LO_W-1 -: DLO_W]};
    assign w3_prod = P3_W'(w3_y) * P3_W'(nydst_pkg::R675_M);

    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            r3_q1 <= r2_q1;
            r3_q2 <= w3_prod[nydst_pkg::R675_S +: DLO_W];
            r3_y  <= w3_y;
            r3_t7 <= r2_lo[SSH-1:0];
        end
    end

    // Stage 4: day number, second of day, shifted day for the era and weekday.
    logic [R1_W-1:0]  w4_r2;
    logic [DAY_W-1:0] w4_days;
    logic [DAY_W-1:0] r4_z;
    logic [DAY_W-1:0] r4_d4;
    logic [SOD_W-1:0] r4_sod;

    assign w4_r2   = R1_W'(r3_y - Y_W'(r3_q2) * Y_W'(nydst_pkg::DAY_ODD));
    assign w4_days = {r3_q1, r3_q2};

    always_ff @(posedge i_clk) begin
        if (w_en[4]) begin
            r4_z   <= w4_days + DAY_W'(nydst_pkg::EPOCH_SHIFT);
            r4_d4  <= w4_days + DAY_W'(nydst_pkg::EPOCH_WEEKDAY);
            r4_sod <= {w4_r2, r3_t7};
        end
    end

    // Stage 5: era and week quotients.
    logic [PERA_W-1:0] w5_pera;
    logic [PWK_W-1:0]  w5_pwk;
    logic [ERA_W-1:0]  r5_era;
    logic [WQ_W-1:0]   r5_wq;
    logic [DAY_W-1:0]  r5_z;
    logic [DAY_W-1:0]  r5_d4;
    logic [SOD_W-1:0]  r5_sod;

    assign w5_pera = PERA_W'(r4_z) * PERA_W'(nydst_pkg::RERA_M);
    assign w5_pwk  = PWK_W'(r4_d4) * PWK_W'(nydst_pkg::RWK_M);

    always_ff @(posedge i_clk) begin
        if (w_en[5]) begin
            r5_era <= w5_pera[nydst_pkg::RERA_S +: ERA_W];
            r5_wq  <= w5_pwk[nydst_pkg::RWK_S +: WQ_W];
            r5_z   <= r4_z;
            r5_d4  <= r4_d4;
            r5_sod <= r4_sod;
        end
    end

    // Stage 6: day of era and weekday of the current day (0 is Sunday).
    logic [DOE_W-1:0] r6_doe;
    logic [WD_W-1:0]  r6_wt;
    logic [SOD_W-1:0] r6_sod;

    always_ff @(posedge i_clk) begin
        if (w_en[6]) begin
            r6_doe <= DOE_W'(r5_z - DAY_W'(r5_era) * DAY_W'(nydst_pkg::DAYS_PER_ERA));
            r6_wt  <= WD_W'(r5_d4 - DAY_W'(r5_wq) * DAY_W'(nydst_pkg::DAYS_PER_WEEK));
            r6_sod <= r5_sod;
        end
    end

    // Stage 7: leap corrections of the day of era.
    logic [P1460_W-1:0] w7_p1460;
    logic [P36K_W-1:0]  w7_p36k;
    logic [Q1460_W-1:0] r7_q1460;
    logic [Q36K_W-1:0]  r7_q36k;
    logic               r7_last;
    logic [DOE_W-1:0]   r7_doe;
    logic [WD_W-1:0]    r7_wt;
    logic [SOD_W-1:0]   r7_sod;

    assign w7_p1460 = P1460_W'(r6_doe) * P1460_W'(nydst_pkg::R1460_M);
    assign w7_p36k  = P36K_W'(r6_doe) * P36K_W'(nydst_pkg::R36524_M);

    always_ff @(posedge i_clk) begin
        if (w_en[7]) begin
            r7_q1460 <= w7_p1460[nydst_pkg::R1460_S +: Q1460_W];
            r7_q36k  <= w7_p36k[nydst_pkg::R36524_S +: Q36K_W];
            r7_last  <= (r6_doe == DOE_W'(nydst_pkg::DAYS_PER_ERA - 1));
            r7_doe   <= r6_doe;
            r7_wt    <= r6_wt;
            r7_sod   <= r6_sod;
        end
    end

    // Stage 8: day of era with leap days removed.
    logic [DOE_W-1:0] r8_n;
    logic [DOE_W-1:0] r8_doe;
    logic [WD_W-1:0]  r8_wt;
    logic [SOD_W-1:0] r8_sod;

    always_ff @(posedge i_clk) begin
        if (w_en[8]) begin
            r8_n   <= r7_doe - DOE_W'(r7_q1460) + DOE_W'(r7_q36k) - DOE_W'(r7_last);
            r8_doe <= r7_doe;
            r8_wt  <= r7_wt;
            r8_sod <= r7_sod;
        end
    end

    // Stage 9: year of era.
    logic [P365_W-1:0] w9_prod;
    logic [YOE_W-1:0]  r9_yoe;
    logic [DOE_W-1:0]  r9_doe;
    logic [WD_W-1:0]   r9_wt;
    logic [SOD_W-1:0]  r9_sod;

    assign w9_prod = P365_W'(r8_n) * P365_W'(nydst_pkg::R365_M);

    always_ff @(posedge i_clk) begin
        if (w_en[9]) begin
            r9_yoe <= w9_prod[nydst_pkg::R365_S +: YOE_W];
            r9_doe <= r8_doe;
            r9_wt  <= r8_wt;
            r9_sod <= r8_sod;
        end
    end

    // Stage 10: days before the year of era.
    logic [P100_W-1:0]  w10_p100;
    logic [DOE_W-1:0]   r10_y365;
    logic [Y100_W-1:0]  r10_y100;
    logic [YOE_W-3:0]   r10_yq4;
    logic [DOE_W-1:0]   r10_doe;
    logic [WD_W-1:0]    r10_wt;
    logic [SOD_W-1:0]   r10_sod;

    assign w10_p100 = P100_W'(r9_yoe) * P100_W'(nydst_pkg::R100_M);

    always_ff @(posedge i_clk) begin
        if (w_en[10]) begin
            r10_y365 <= DOE_W'(r9_yoe) * DOE_W'(nydst_pkg::DAYS_PER_YEAR);
            r10_y100 <= w10_p100[nydst_pkg::R100_S +: Y100_W];
            r10_yq4  <= r9_yoe[YOE_W-1:2];
            r10_doe  <= r9_doe;
            r10_wt   <= r9_wt;
            r10_sod  <= r9_sod;
        end
    end

    // Stage 11: day of the March-based year (0 is March 1).
    logic [DOY_W-1:0] r11_doy;
    logic [WD_W-1:0]  r11_wt;
    logic [SOD_W-1:0] r11_sod;

    always_ff @(posedge i_clk) begin
        if (w_en[11]) begin
            r11_doy <= DOY_W'(r10_doe
                       - (r10_y365 + DOE_W'(r10_yq4) - DOE_W'(r10_y100)));
            r11_wt  <= r10_wt;
            r11_sod <= r10_sod;
        end
    end

    // Stage 12: weeks since March 1.
    logic [PDW_W-1:0] w12_prod;
    logic [DQ_W-1:0]  r12_dq;
    logic [DOY_W-1:0] r12_doy;
    logic [WD_W-1:0]  r12_wt;
    logic [SOD_W-1:0] r12_sod;

    assign w12_prod = PDW_W'(r11_doy) * PDW_W'(nydst_pkg::RDW_M);

    always_ff @(posedge i_clk) begin
        if (w_en[12]) begin
            r12_dq  <= w12_prod[nydst_pkg::RDW_S +: DQ_W];
            r12_doy <= r11_doy;
            r12_wt  <= r11_wt;
            r12_sod <= r11_sod;
        end
    end

    // Stage 13: weekday of March 1 and the days from it to the next Sunday.
    // November 1 lies 35 weeks after March 1, so it has the same weekday.
    logic [WD_W-1:0]  w13_dr;
    logic [WM_W-1:0]  w13_wm_raw;
    logic [WD_W-1:0]  w13_wm;
    logic [WD_W-1:0]  w13_a;
    logic [WD_W-1:0]  r13_a;
    logic [DOY_W-1:0] r13_doy;
    logic [SOD_W-1:0] r13_sod;

    always_comb begin
        w13_dr     = WD_W'(r12_doy - DOY_W'(r12_dq) * DOY_W'(nydst_pkg::DAYS_PER_WEEK));
        w13_wm_raw = WM_W'(r12_wt) + WEEK_WM - WM_W'(w13_dr);
        if (w13_wm_raw >= WEEK_WM) begin
            w13_wm = WD_W'(w13_wm_raw - WEEK_WM);
        end else begin
            w13_wm = WD_W'(w13_wm_raw);
        end
        w13_a = (w13_wm == '0) ? '0 : WEEK_WD - w13_wm;
    end

    always_ff @(posedge i_clk) begin
        if (w_en[13]) begin
            r13_a   <= w13_a;
            r13_doy <= r12_doy;
            r13_sod <= r12_sod;
        end
    end

    // Stage 14: half-open compare against the two transition instants.
    logic [DOY_W-1:0]          w14_sdoy;
    logic [DOY_W-1:0]          w14_edoy;
    logic                      w14_after_start;
    logic                      w14_before_end;
    logic                      w14_dst;
    logic                      r14_dst;
    nydst_pkg::t_offset        r14_ofs;

    always_comb begin
        w14_sdoy        = DOY_W'(nydst_pkg::SUN2_OFS) + DOY_W'(r13_a);
        w14_edoy        = DOY_W'(nydst_pkg::NOV_OFS) + DOY_W'(r13_a);
        w14_after_start = (r13_doy > w14_sdoy)
                          || ((r13_doy == w14_sdoy) && (r13_sod >= SOD_START_V));
        w14_before_end  = (r13_doy < w14_edoy)
                          || ((r13_doy == w14_edoy) && (r13_sod < SOD_END_V));
        w14_dst         = w14_after_start && w14_before_end;
    end

    always_ff @(posedge i_clk) begin
        if (w_en[14]) begin
            r14_dst <= w14_dst;
            r14_ofs <= w14_dst ? nydst_pkg::OFS_DST : nydst_pkg::OFS_STD;
        end
    end

    assign o_result.valid          = r_v[NS-1];
    assign o_result.dst_active     = r14_dst;
    assign o_result.offset_minutes = r14_ofs;

    // Checks on the pipeline control and the calendar arithmetic.
    `NYDST_ASSERT_NEXT(a_stall_keeps, i_clk, i_rst_n, 1'b1, ((r_v & $past(r_v & ~w_en)) == $past(r_v & ~w_en)), "stalled stage lost its item")
    `NYDST_ASSERT_NOW(a_sod_range, i_clk, i_rst_n, r_v[4], (r4_sod < SOD_DAY_V), "second of day out of range")
    `NYDST_ASSERT_NOW(a_doe_range, i_clk, i_rst_n, r_v[6], ((r6_doe < DOE_W'(nydst_pkg::DAYS_PER_ERA)) && (r6_wt < WEEK_WD)), "day of era or weekday out of range")
    `NYDST_ASSERT_NOW(a_doy_range, i_clk, i_rst_n, r_v[11], (r11_doy < DOY_W'(nydst_pkg::DAYS_PER_YEAR + 1)), "day of year out of range")
    `NYDST_ASSERT_NOW(a_ofs_match, i_clk, i_rst_n, r_v[NS-1], (r14_dst ? (r14_ofs == nydst_pkg::OFS_DST) : (r14_ofs == nydst_pkg::OFS_STD)), "offset disagrees with DST flag")

endmodule

// ----- tb/nydst_checker.sv -----
// Checker for the New York offset block: watches the item and result channels,
// predicts each result from its timestamp and compares in order. Depends on nydst_pkg, nydst_if.
module nydst_checker #(
    parameter int TIME_BITS = nydst_pkg::TIME_W
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    nydst_in_if   i_item_mon,
    nydst_out_if  i_result_mon,
    output int    o_fail_count,
    output int    o_pending,
    output int    o_checked,
    output int    o_dst_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        nydst_pkg::t_time   stamp;
        nydst_pkg::t_offset offset_minutes;
        logic               dst_active;
    } t_offset_expect;

    t_offset_expect expected_offsets[$];
    int             fail_count;
    int             checked;
    int             dst_seen;

    // Weekday (0 = Sunday) of the first day of a month at or after March, by Zeller.
    function automatic logic [63:0] zeller_first_weekday(input logic [63:0] year,
                                                         input logic [63:0] month);
        logic [63:0] k;
        logic [63:0] j;
        logic [63:0] h;
        k = year % 64'd100;
        j = year / 64'd100;
        h = (64'd1 + (64'd13 * (month + 64'd1)) / 64'd5 + k + k / 64'd4 + j / 64'd4
             + 64'd5 * j) % 64'd7;
        return (h + 64'd6) % 64'd7;
    endfunction

    // Days since 1970-01-01 of a date at or after March.
    function automatic logic [63:0] civil_day_index(input logic [63:0] year,
                                                    input logic [63:0] month,
                                                    input logic [63:0] mday);
        logic [63:0] era;
        logic [63:0] yoe;
        logic [63:0] doy;
        logic [63:0] doe;
        era = year / 64'd400;
        yoe = year - era * 64'd400;
        doy = (64'd153 * (month - 64'd3) + 64'd2) / 64'd5 + mday - 64'd1;
        doe = yoe * 64'd365 + yoe / 64'd4 - yoe / 64'd100 + doy;
        return era * 64'd146097 + doe - 64'd719468;
    endfunction

    // Expected offset and daylight flag for one timestamp.
    function automatic t_offset_expect predict_offset(input nydst_pkg::t_time stamp);
        t_offset_expect res;
        logic [63:0] secs;
        logic [63:0] z;
        logic [63:0] era;
        logic [63:0] doe;
        logic [63:0] yoe;
        logic [63:0] doy;
        logic [63:0] mp;
        logic [63:0] year;
        logic [63:0] sun_mar;
        logic [63:0] sun_nov;
        logic [63:0] start_secs;
        logic [63:0] end_secs;
        logic        dst;
        secs = 64'(stamp) & ((64'd1 << TIME_BITS) - 64'd1);
        z    = secs / 64'd86400 + 64'd719468;
        era  = z / 64'd146097;
        doe  = z - era * 64'd146097;
        yoe  = (doe - doe / 64'd1460 + doe / 64'd36524 - doe / 64'd146096) / 64'd365;
        doy  = doe - (64'd365 * yoe + yoe / 64'd4 - yoe / 64'd100);
        mp   = (64'd5 * doy + 64'd2) / 64'd153;
        year = yoe + era * 64'd400 + ((mp >= 64'd10) ? 64'd1 : 64'd0);

        // Second Sunday of March and first Sunday of November.
        sun_mar = 64'd1 + (64'd7 - zeller_first_weekday(year, 64'd3)) % 64'd7 + 64'd7;
        sun_nov = 64'd1 + (64'd7 - zeller_first_weekday(year, 64'd11)) % 64'd7;

        // 02:00 local on each date, expressed in UTC.
        start_secs = civil_day_index(year, 64'd3, sun_mar) * 64'd86400
                     + 64'(nydst_pkg::SOD_START);
        end_secs   = civil_day_index(year, 64'd11, sun_nov) * 64'd86400
                     + 64'(nydst_pkg::SOD_END);

        dst = (secs >= start_secs) && (secs < end_secs);
        res.stamp          = stamp;
        res.offset_minutes = dst ? nydst_pkg::OFS_DST : nydst_pkg::OFS_STD;
        res.dst_active     = dst;
        return res;
    endfunction

    // Predict on every accepted item, compare on every accepted result.
    always @(posedge i_clk) begin
        t_offset_expect want;
        if (i_rst_n) begin
            if (i_item_mon.valid && i_item_mon.ready) begin
                expected_offsets.push_back(predict_offset(i_item_mon.utc_seconds));
            end
            if (i_result_mon.valid && i_result_mon.ready) begin
                if (expected_offsets.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected result: offset %0d dst %0b", $time,
                             i_result_mon.offset_minutes, i_result_mon.dst_active);
                end else begin
                    want = expected_offsets.pop_front();
                    checked++;
                    if (i_result_mon.dst_active === 1'b1) begin
                        dst_seen++;
                    end
                    if (i_result_mon.offset_minutes !== want.offset_minutes ||
                        i_result_mon.dst_active !== want.dst_active) begin
                        fail_count++;
                        $display({"%0t: mismatch for t=%0d: expected offset %0d dst %0b,",
                                  " got offset %0d dst %0b"},
                                 $time, want.stamp, want.offset_minutes, want.dst_active,
                                 i_result_mon.offset_minutes, i_result_mon.dst_active);
                    end
                end
            end
        end
        o_fail_count = fail_count;
        o_pending    = expected_offsets.size();
        o_checked    = checked;
        o_dst_seen   = dst_seen;
    end

endmodule

// ----- tb/new_york_dst_offset_top_tb.sv -----
// Testbench top for the New York offset block: clock, reset, item stimulus with idling
// and a long output stall, watchdog and verdict. Depends on nydst_pkg, nydst_if, nydst_checker.
module new_york_dst_offset_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint TIME_MAX       = (64'd1 << nydst_pkg::TIME_W) - 1;
    localparam int     RANDOM_PER_PHASE = 250;
    localparam int     STALL_CYCLES   = 60;
    localparam int     DRAIN_CYCLES   = 30;
    localparam int     WATCHDOG_LIMIT = 2000;

    logic i_clk;
    logic i_rst_n;

    nydst_in_if  item_ch ();
    nydst_out_if result_ch ();

    int fail_count;
    int pending;
    int checked;
    int dst_seen;

    int src_idle_pct;
    int sink_idle_pct;
    int items_sent;
    bit stall_req;
    int idle_cycles;

    new_york_dst_offset_top #(
        .TIME_BITS (nydst_pkg::TIME_W)
    ) i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch),
        .o_result (result_ch)
    );

    nydst_checker #(
        .TIME_BITS (nydst_pkg::TIME_W)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_mon   (item_ch),
        .i_result_mon (result_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_dst_seen   (dst_seen)
    );

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Days since 1970-01-01 of a date at or after March, for aiming items at the transitions.
    function automatic longint days_since_epoch(input longint year, input longint month,
                                                input longint mday);
        longint era;
        longint yoe;
        longint doe;
        era = year / 400;
        yoe = year - era * 400;
        doe = yoe * 365 + yoe / 4 - yoe / 100 + (153 * (month - 3) + 2) / 5 + mday - 1;
        return era * 146097 + doe - 719468;
    endfunction

    // UTC second at which daylight time starts (at_end = 0) or ends (at_end = 1) in a year.
    function automatic longint dst_edge_secs(input longint year, input bit at_end);
        longint first_day;
        longint wday;
        first_day = days_since_epoch(year, at_end ? 11 : 3, 1);
        // 1970-01-01 was a Thursday.
        wday = (first_day + nydst_pkg::EPOCH_WEEKDAY) % 7;
        if (at_end) begin
            return (first_day + (7 - wday) % 7) * 86400 + nydst_pkg::SOD_END;
        end else begin
            return (first_day + (7 - wday) % 7 + 7) * 86400 + nydst_pkg::SOD_START;
        end
    endfunction

    function automatic nydst_pkg::t_time clamp_stamp(input longint v);
        if (v < 0) begin
            return '0;
        end else if (v > TIME_MAX) begin
            return nydst_pkg::t_time'(TIME_MAX);
        end else begin
            return nydst_pkg::t_time'(v);
        end
    endfunction

    // Random timestamp: near a transition, anywhere in the field, or in the present era.
    function automatic nydst_pkg::t_time random_stamp();
        longint edge_secs;
        longint delta;
        case ($urandom_range(9, 0))
            0, 1, 2, 3: begin
                edge_secs = dst_edge_secs(longint'($urandom_range(36810, 1970)),
                                          1'($urandom_range(1, 0)));
                if ($urandom_range(1, 0)) begin
                    delta = longint'($urandom_range(8, 0)) - 4;
                end else begin
                    delta = longint'($urandom_range(172800, 0)) - 86400;
                end
                return clamp_stamp(edge_secs + delta);
            end
            4, 5, 6: return nydst_pkg::t_time'({$urandom, $urandom});
            default: return nydst_pkg::t_time'({$urandom_range(1, 0), $urandom});
        endcase
    endfunction

    // Offer one item, idling first at the current rate, and hold it until accepted.
    task automatic send_item(input nydst_pkg::t_time stamp);
        while ($urandom_range(99, 0) < src_idle_pct) begin
            item_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        item_ch.valid       <= 1'b1;
        item_ch.utc_seconds <= stamp;
        do begin
            @(posedge i_clk);
        end while (!item_ch.ready);
        items_sent++;
        @(negedge i_clk);
    endtask

    // Aimed at the edges of the field, the transitions and the calendar corners.
    task automatic send_directed();
        send_item('0);
        send_item(nydst_pkg::t_time'(TIME_MAX));
        send_item(nydst_pkg::t_time'(40'hAA_AAAA_AAAA));
        send_item(nydst_pkg::t_time'(40'h55_5555_5555));
        send_item(clamp_stamp(dst_edge_secs(2024, 1'b0) - 1));
        send_item(clamp_stamp(dst_edge_secs(2024, 1'b0)));
        send_item(clamp_stamp(dst_edge_secs(2024, 1'b1) - 1));
        send_item(clamp_stamp(dst_edge_secs(2024, 1'b1)));
        // Leap and non-leap century years.
        send_item(clamp_stamp(dst_edge_secs(2000, 1'b0)));
        send_item(clamp_stamp(dst_edge_secs(2000, 1'b1) - 1));
        send_item(clamp_stamp(dst_edge_secs(2100, 1'b0) - 1));
        send_item(clamp_stamp(dst_edge_secs(2100, 1'b1)));
        send_item(clamp_stamp(dst_edge_secs(1970, 1'b0)));
        // New Year, end of February in a leap year, and midsummer.
        send_item(nydst_pkg::t_time'(40'd1704067199));
        send_item(nydst_pkg::t_time'(40'd1704067200));
        send_item(nydst_pkg::t_time'(40'd1709251199));
        send_item(nydst_pkg::t_time'(40'd1720051200));
        // 32-bit rollover and the last transitions that fit in the field.
        send_item(nydst_pkg::t_time'(40'hFFFF_FFFF));
        send_item(nydst_pkg::t_time'(40'h1_0000_0000));
        send_item(clamp_stamp(dst_edge_secs(36811, 1'b0)));
        send_item(clamp_stamp(dst_edge_secs(36811, 1'b1) - 1));
        send_item(clamp_stamp(dst_edge_secs(36812, 1'b0) - 1));
    endtask

    // Receiver: random back-pressure, plus one long hold-off on request.
    initial begin
        int stall_left;
        bit stall_done;
        stall_left = 0;
        stall_done = 1'b0;
        result_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                result_ch.ready <= 1'b0;
                stall_left--;
            end else if (stall_req && !stall_done) begin
                result_ch.ready <= 1'b0;
                stall_done = 1'b1;
                stall_left = STALL_CYCLES - 1;
            end else begin
                result_ch.ready <= ($urandom_range(99, 0) >= sink_idle_pct);
            end
        end
    end

    // Watchdog: ends the run after too many cycles with nothing accepted.
    initial begin
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("%0t: watchdog expired with %0d results outstanding", $time, pending);
        $display("FAILURE");
        $finish;
    end

    // Reset, three idling phases, drain and verdict.
    initial begin
        i_rst_n             = 1'b0;
        item_ch.valid       = 1'b0;
        item_ch.utc_seconds = '0;
        src_idle_pct        = 0;
        sink_idle_pct       = 0;
        items_sent          = 0;
        stall_req           = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    src_idle_pct  = 27;
                    sink_idle_pct = 82;
                end
                1: begin
                    src_idle_pct  = 82;
                    sink_idle_pct = 27;
                end
                default: begin
                    src_idle_pct  = 0;
                    sink_idle_pct = 0;
                    // The sender keeps offering while the receiver holds off.
                    stall_req = 1'b1;
                end
            endcase
            if (phase == 0) begin
                send_directed();
            end
            repeat (RANDOM_PER_PHASE) send_item(random_stamp());
        end
        item_ch.valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d timestamps under three idling mixes and a %0d-cycle output stall;",
                 items_sent, STALL_CYCLES);
        $display("checked %0d results, %0d of them in daylight time.", checked, dst_seen);
        if (fail_count == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
